>>> hdl/gap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_pkg
// shared constants, register codes and beat types of the global average pool
// ----------------------------------------------------------------------------
package gap_pkg;

   localparam int MAX_CHANNELS = 256;
   localparam int CHAN_BITS    = $clog2(MAX_CHANNELS);
   localparam int CHCNT_BITS   = CHAN_BITS + 1;
   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_SIDE     = 64;
   localparam int DIM_BITS     = $clog2(MAX_SIDE) + 1;
   localparam int NPIX_BITS    = 2 * DIM_BITS - 1;
   localparam int PIX_BITS     = NPIX_BITS - 1;
   localparam int SUM_BITS     = SAMPLE_BITS + PIX_BITS;
   localparam int FRAC_SHIFT   = 16;
   localparam int RECIP_BITS   = FRAC_SHIFT + 1;
   localparam int RECIP_RESET  = 16384;
   localparam int PROD_BITS    = SUM_BITS + RECIP_BITS + 1;
   localparam int QUOT_BITS    = PROD_BITS - FRAC_SHIFT;
   localparam int REM_BITS     = NPIX_BITS;
   localparam int DIV_CNT_BITS = $clog2(RECIP_BITS);

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_MAP_HEIGHT    = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MAP_WIDTH     = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(2);
   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(2);
   localparam logic [CHCNT_BITS-1:0] CHCNT_RESET  = CHCNT_BITS'(256);

   // short queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   // result queue, one slot per beat that may be in flight in the back part
   localparam int OUT_DEPTH    = 8;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;
   localparam logic [OUT_CNT_BITS-1:0] OUT_FULL = OUT_CNT_BITS'(OUT_DEPTH);

   typedef struct packed {
      logic                    restart;
      logic                    busy;
      logic [NPIX_BITS-1:0]    npix;
      logic [CHCNT_BITS-1:0]   chans;
      logic [RECIP_BITS-1:0]   recip;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_BITS-1:0]          chan;
      logic                          first_pixel;
      logic                          emit;
      logic                          last_chan;
   } item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic [CHAN_BITS-1:0]          channel_index;
      logic                          last_channel;
   } result_type;

endpackage

>>> hdl/gap_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap stream channels
// valid/ready channels for sample beats and average beats
// ----------------------------------------------------------------------------
interface gap_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gap_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface gap_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gap_pkg::SAMPLE_BITS-1:0] average;
   logic [gap_pkg::CHAN_BITS-1:0]          channel_index;
   logic                                  last_channel;

   modport source (output valid, output average, output channel_index,
                   output last_channel, input ready);
   modport sink   (input valid, input average, input channel_index,
                   input last_channel, output ready);
endinterface

>>> hdl/gap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_ram
// generic single-write single-read memory, registered read, read-old on collision
// ----------------------------------------------------------------------------
module gap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gap_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_csr
// map geometry registers and the bit-serial reciprocal divider
// ----------------------------------------------------------------------------
module gap_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gap_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [gap_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [gap_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output gap_pkg::cfg_type                  cfg
);

   logic [gap_pkg::DIM_BITS-1:0]     height_ff, height_in;
   logic [gap_pkg::DIM_BITS-1:0]     width_ff, width_in;
   logic [gap_pkg::CHCNT_BITS-1:0]   chcnt_ff, chcnt_in;
   logic                             busy_ff, busy_in;
   logic [gap_pkg::DIV_CNT_BITS-1:0] step_ff, step_in;
   logic [gap_pkg::REM_BITS-1:0]     rem_ff, rem_in;
   logic [gap_pkg::RECIP_BITS-1:0]   quo_ff, quo_in;
   logic [gap_pkg::RECIP_BITS-1:0]   recip_ff, recip_in;

   logic [gap_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic                             wr_strobe;
   logic                             known_reg;
   logic [gap_pkg::DIM_BITS-1:0]     used_h, used_w;
   logic [gap_pkg::CHCNT_BITS-1:0]   used_c;
   logic [gap_pkg::NPIX_BITS-1:0]    npix;
   logic [gap_pkg::REM_BITS:0]       trial;
   logic                             fits;

   assign reg_idx   = csr_paddr[gap_pkg::REG_IDX_BITS+1:2];
   assign wr_strobe = csr_psel && csr_penable && csr_pwrite;
   assign known_reg = (reg_idx == gap_pkg::REG_MAP_HEIGHT) ||
                      (reg_idx == gap_pkg::REG_MAP_WIDTH) ||
                      (reg_idx == gap_pkg::REG_CHANNEL_COUNT);

   // zero is used as one, oversize as the maximum
   always_comb begin
      used_h = height_ff;
      if (height_ff == '0) begin
         used_h = gap_pkg::DIM_BITS'(1);
      end else if (height_ff > gap_pkg::DIM_BITS'(gap_pkg::MAX_SIDE)) begin
         used_h = gap_pkg::DIM_BITS'(gap_pkg::MAX_SIDE);
      end
      used_w = width_ff;
      if (width_ff == '0) begin
         used_w = gap_pkg::DIM_BITS'(1);
      end else if (width_ff > gap_pkg::DIM_BITS'(gap_pkg::MAX_SIDE)) begin
         used_w = gap_pkg::DIM_BITS'(gap_pkg::MAX_SIDE);
      end
      used_c = chcnt_ff;
      if (chcnt_ff == '0) begin
         used_c = gap_pkg::CHCNT_BITS'(1);
      end else if (chcnt_ff > gap_pkg::CHCNT_BITS'(gap_pkg::MAX_CHANNELS)) begin
         used_c = gap_pkg::CHCNT_BITS'(gap_pkg::MAX_CHANNELS);
      end
   end

   assign npix = gap_pkg::NPIX_BITS'(used_h) * gap_pkg::NPIX_BITS'(used_w);

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      chcnt_in  = chcnt_ff;
      if (wr_strobe) begin
         case (reg_idx)
            gap_pkg::REG_MAP_HEIGHT:    height_in = csr_pwdata[gap_pkg::DIM_BITS-1:0];
            gap_pkg::REG_MAP_WIDTH:     width_in  = csr_pwdata[gap_pkg::DIM_BITS-1:0];
            gap_pkg::REG_CHANNEL_COUNT: chcnt_in  = csr_pwdata[gap_pkg::CHCNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // restoring division of 2^16 by the pixel count, one quotient bit a cycle
   assign trial = {rem_ff, (step_ff == '0)};
   assign fits  = trial >= {1'b0, npix};

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      recip_in = recip_ff;
      if (wr_strobe && known_reg) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? gap_pkg::REM_BITS'(trial - {1'b0, npix})
                        : trial[gap_pkg::REM_BITS-1:0];
         quo_in  = {quo_ff[gap_pkg::RECIP_BITS-2:0], fits};
         step_in = step_ff + gap_pkg::DIV_CNT_BITS'(1);
         if (step_ff == gap_pkg::DIV_CNT_BITS'(gap_pkg::RECIP_BITS - 1)) begin
            busy_in  = 1'b0;
            recip_in = quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= gap_pkg::HEIGHT_RESET;
         width_ff  <= gap_pkg::WIDTH_RESET;
         chcnt_ff  <= gap_pkg::CHCNT_RESET;
         busy_ff   <= 1'b0;
         step_ff   <= '0;
         recip_ff  <= gap_pkg::RECIP_BITS'(gap_pkg::RECIP_RESET);
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         chcnt_ff  <= chcnt_in;
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         recip_ff  <= recip_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      case (reg_idx)
         gap_pkg::REG_MAP_HEIGHT:    csr_prdata = gap_pkg::CSR_DATA_BITS'(height_ff);
         gap_pkg::REG_MAP_WIDTH:     csr_prdata = gap_pkg::CSR_DATA_BITS'(width_ff);
         gap_pkg::REG_CHANNEL_COUNT: csr_prdata = gap_pkg::CSR_DATA_BITS'(chcnt_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign cfg.restart = wr_strobe && known_reg;
   assign cfg.busy    = busy_ff;
   assign cfg.npix    = npix;
   assign cfg.chans   = used_c;
   assign cfg.recip   = recip_ff;

endmodule

>>> hdl/gap_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_front
// tracks channel and pixel position, tags each sample beat, queues it
// ----------------------------------------------------------------------------
module gap_front (
   input  logic              clock,
   input  logic              reset,
   input  gap_pkg::cfg_type  cfg,
   gap_req_if.sink           req,
   output gap_pkg::item_type q_head,
   output logic              q_valid,
   input  logic              q_pop
);

   logic [gap_pkg::CHAN_BITS-1:0]      chan_ff, chan_in;
   logic [gap_pkg::PIX_BITS-1:0]       pix_ff, pix_in;
   gap_pkg::item_type                  queue_ff [gap_pkg::QUEUE_DEPTH];
   logic [gap_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [gap_pkg::QUEUE_CNT_BITS-1:0] count_ff;

   logic                               push;
   logic                               full;
   logic [gap_pkg::NPIX_BITS-1:0]      pix_plus;
   logic [gap_pkg::CHCNT_BITS-1:0]     chan_plus;
   gap_pkg::item_type                  item;

   assign full      = count_ff == gap_pkg::QUEUE_CNT_BITS'(gap_pkg::QUEUE_DEPTH);
   assign req.ready = !full && !cfg.busy;
   assign push      = req.valid && req.ready;

   assign pix_plus  = {1'b0, pix_ff} + gap_pkg::NPIX_BITS'(1);
   assign chan_plus = {1'b0, chan_ff} + gap_pkg::CHCNT_BITS'(1);

   always_comb begin
      item.sample      = req.sample;
      item.chan        = chan_ff;
      item.first_pixel = pix_ff == '0;
      item.emit        = pix_plus >= cfg.npix;
      item.last_chan   = chan_plus >= cfg.chans;
   end

   always_comb begin
      chan_in = chan_ff;
      pix_in  = pix_ff;
      if (cfg.restart) begin
         chan_in = '0;
         pix_in  = '0;
      end else if (push) begin
         if (item.last_chan) begin
            chan_in = '0;
            pix_in  = item.emit ? '0 : pix_plus[gap_pkg::PIX_BITS-1:0];
         end else begin
            chan_in = chan_plus[gap_pkg::CHAN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff   <= '0;
         pix_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         chan_ff   <= chan_in;
         pix_ff    <= pix_in;
         wr_ptr_ff <= wr_ptr_ff + gap_pkg::QUEUE_PTR_BITS'(push);
         rd_ptr_ff <= rd_ptr_ff + gap_pkg::QUEUE_PTR_BITS'(q_pop);
         count_ff  <= count_ff + gap_pkg::QUEUE_CNT_BITS'(push)
                               - gap_pkg::QUEUE_CNT_BITS'(q_pop);
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_valid = count_ff != '0;
   assign q_head  = queue_ff[rd_ptr_ff];

endmodule

>>> hdl/gap_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_back
// accumulator read-modify-write, scaling multiply, saturation, result queue
// ----------------------------------------------------------------------------
module gap_back (
   input  logic              clock,
   input  logic              reset,
   input  gap_pkg::cfg_type  cfg,
   input  gap_pkg::item_type q_head,
   input  logic              q_valid,
   output logic              q_pop,
   gap_rsp_if.source         rsp
);

   // accumulate stage
   logic                                p1_valid_ff;
   gap_pkg::item_type                   p1_item_ff;
   logic [gap_pkg::SUM_BITS-1:0]        ram_rd_data;
   logic signed [gap_pkg::SUM_BITS-1:0] old_sum, new_sum, sample_ext;

   // multiply stage
   logic                                p2_valid_ff, p2_emit_ff, p2_last_ff;
   logic [gap_pkg::CHAN_BITS-1:0]       p2_chan_ff;
   logic signed [gap_pkg::SUM_BITS-1:0] p2_sum_ff;
   logic signed [gap_pkg::PROD_BITS-1:0] prod;

   // saturate stage
   logic                                 p3_valid_ff, p3_last_ff;
   logic [gap_pkg::CHAN_BITS-1:0]        p3_chan_ff;
   logic signed [gap_pkg::PROD_BITS-1:0] p3_prod_ff;
   logic [gap_pkg::QUOT_BITS-1:0]        quot;
   logic [gap_pkg::QUOT_BITS-gap_pkg::SAMPLE_BITS:0] quot_top;
   gap_pkg::result_type                  result;

   // result queue and slot credits
   gap_pkg::result_type                out_ff [gap_pkg::OUT_DEPTH];
   logic [gap_pkg::OUT_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [gap_pkg::OUT_CNT_BITS-1:0]   count_ff, credit_ff;
   logic                               take;
   logic                               claim;

   // an emitting beat enters only with a free result slot reserved for it
   assign q_pop = q_valid && (!q_head.emit || (credit_ff < gap_pkg::OUT_FULL));
   assign claim = q_pop && q_head.emit;
   assign take  = rsp.valid && rsp.ready;

   gap_ram #(
      .WIDTH (gap_pkg::SUM_BITS),
      .DEPTH (gap_pkg::MAX_CHANNELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_item_ff.chan),
      .wr_data (new_sum),
      .rd_addr (q_head.chan),
      .rd_data (ram_rd_data)
   );

   // the write of the beat just ahead, now in p2, is not yet in the read data
   assign old_sum = (p2_valid_ff && (p2_chan_ff == p1_item_ff.chan))
                    ? p2_sum_ff : $signed(ram_rd_data);
   assign sample_ext = {{(gap_pkg::SUM_BITS-gap_pkg::SAMPLE_BITS)
                         {p1_item_ff.sample[gap_pkg::SAMPLE_BITS-1]}},
                        p1_item_ff.sample};
   assign new_sum = p1_item_ff.first_pixel ? sample_ext : old_sum + sample_ext;

   assign prod = p2_sum_ff * $signed({1'b0, cfg.recip});

   // floor shift, then clamp to the sample range
   assign quot     = p3_prod_ff[gap_pkg::PROD_BITS-1:gap_pkg::FRAC_SHIFT];
   assign quot_top = quot[gap_pkg::QUOT_BITS-1:gap_pkg::SAMPLE_BITS-1];

   always_comb begin
      if ((&quot_top) || !(|quot_top)) begin
         result.average = quot[gap_pkg::SAMPLE_BITS-1:0];
      end else if (quot[gap_pkg::QUOT_BITS-1]) begin
         result.average = {1'b1, {(gap_pkg::SAMPLE_BITS-1){1'b0}}};
      end else begin
         result.average = {1'b0, {(gap_pkg::SAMPLE_BITS-1){1'b1}}};
      end
      result.channel_index = p3_chan_ff;
      result.last_channel  = p3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         credit_ff   <= '0;
      end else begin
         p1_valid_ff <= q_pop;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff && p2_emit_ff;
         wr_ptr_ff   <= wr_ptr_ff + gap_pkg::OUT_PTR_BITS'(p3_valid_ff);
         rd_ptr_ff   <= rd_ptr_ff + gap_pkg::OUT_PTR_BITS'(take);
         count_ff    <= count_ff + gap_pkg::OUT_CNT_BITS'(p3_valid_ff)
                                 - gap_pkg::OUT_CNT_BITS'(take);
         credit_ff   <= credit_ff + gap_pkg::OUT_CNT_BITS'(claim)
                                  - gap_pkg::OUT_CNT_BITS'(take);
      end
      p1_item_ff <= q_head;
      p2_sum_ff  <= new_sum;
      p2_chan_ff <= p1_item_ff.chan;
      p2_emit_ff <= p1_item_ff.emit;
      p2_last_ff <= p1_item_ff.last_chan;
      p3_prod_ff <= prod;
      p3_chan_ff <= p2_chan_ff;
      p3_last_ff <= p2_last_ff;
      if (p3_valid_ff) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp.valid         = count_ff != '0;
   assign rsp.average       = out_ff[rd_ptr_ff].average;
   assign rsp.channel_index = out_ff[rd_ptr_ff].channel_index;
   assign rsp.last_channel  = out_ff[rd_ptr_ff].last_channel;

endmodule

>>> hdl/global_average_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// global_average_pool
// per-channel mean of a channel-last feature map, signed Q8.8 in and out
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_bus  | in        | valid/ready         | sample (s16 Q8.8)
//  rsp_bus  | out       | valid/ready         | average (s16), channel_index (8),
//           |           |                     | last_channel (1)
//  csr_*    | in/out    | apb, pready tied 1  | map_height @0, map_width @4,
//           |           |                     | channel_count @8
//
//  one sample beat per cycle sustained while the divider is idle and the beat
//  queue has room; a beat of the last pixel reaches rsp_bus through queue pop
//  with ram read, add, multiply, and clamp into the result queue
//  a csr write to a known register restarts the map and runs the reciprocal
//  divider, one quotient bit a cycle, with req_bus.ready low meanwhile
//  reset is synchronous; accumulators are not cleared, the first pixel
//  overwrites them
//  rsp stalls fill an 8-deep result queue, then the back part stops pulling
//  from the 2-deep beat queue, and only then req_bus.ready drops
// ----------------------------------------------------------------------------
module global_average_pool (
   input  logic                              clock,
   input  logic                              reset,
   gap_req_if.sink                           req_bus,
   gap_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gap_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [gap_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [gap_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   // geometry, reciprocal and restart pulse shared by front and back
   gap_pkg::cfg_type  cfg;
   // head of the beat queue between front and back
   gap_pkg::item_type q_head;
   logic              q_valid;
   logic              q_pop;

   // registers and reciprocal divider
   gap_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // position tracking: tags first pixel, last pixel and last channel
   gap_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_bus),
      .q_head  (q_head),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // accumulate, scale by the reciprocal, clamp, queue results
   gap_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_head  (q_head),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

`ifndef ASSERT_OFF
   // no sample beat is taken while the reciprocal is being worked out
   a_no_beat_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> !cfg.busy)
      else $error("sample beat taken during reciprocal division");

   // a write to a known register always starts the divider
   a_restart_starts_divider: assert property (@(posedge clock) disable iff (reset)
      cfg.restart |=> cfg.busy)
      else $error("register write did not start the divider");

   // the back part only pulls from a non-empty beat queue
   a_pop_needs_beat: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("beat queue popped while empty");

   // the reciprocal is never zero once the divider is idle
   a_recip_nonzero: assert property (@(posedge clock) disable iff (reset)
      !cfg.busy |=> cfg.recip != '0)
      else $error("reciprocal is zero");
`endif

endmodule

>>> tb/gap_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_average_checker
// watches the sample, average and csr ports of the global average pool, keeps
// its own channel sums and map position, and compares every average beat
// ----------------------------------------------------------------------------
module gap_average_checker (
   input  logic                              clock,
   input  logic                              reset,
   gap_req_if                                req,
   gap_rsp_if                                rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [gap_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [gap_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                                mismatches,
   output int                                pending,
   output int                                map_beats
);

   logic [gap_pkg::DIM_BITS-1:0]   height_reg;
   logic [gap_pkg::DIM_BITS-1:0]   width_reg;
   logic [gap_pkg::CHCNT_BITS-1:0] chcnt_reg;
   longint                         chan_sum [gap_pkg::MAX_CHANNELS];
   int                             chan_pos;
   int                             pix_pos;
   int                             bad_beats;
   gap_pkg::result_type            expected_averages [$];

   // zero means one, oversize means the maximum
   function automatic int used_dim(input int raw, input int limit);
      if (raw == 0) return 1;
      return (raw > limit) ? limit : raw;
   endfunction

   always @(posedge clock) begin : track
      int                               npix;
      int                               chans;
      longint                           avg;
      gap_pkg::result_type              want;
      gap_pkg::result_type              got;
      logic [gap_pkg::REG_IDX_BITS-1:0] reg_idx;
      if (reset) begin
         height_reg = gap_pkg::HEIGHT_RESET;
         width_reg  = gap_pkg::WIDTH_RESET;
         chcnt_reg  = gap_pkg::CHCNT_RESET;
         chan_pos   = 0;
         pix_pos    = 0;
         bad_beats  = 0;
         expected_averages.delete();
      end else begin
         npix  = used_dim(int'(height_reg), gap_pkg::MAX_SIDE)
                 * used_dim(int'(width_reg), gap_pkg::MAX_SIDE);
         chans = used_dim(int'(chcnt_reg), gap_pkg::MAX_CHANNELS);

         // average beats leave first, so an average beat in the same cycle as its sample cannot match
         if (rsp.valid && rsp.ready) begin
            got.average       = rsp.average;
            got.channel_index = rsp.channel_index;
            got.last_channel  = rsp.last_channel;
            if (expected_averages.size() == 0) begin
               if (bad_beats < 10)
                  $display("unexpected average beat: avg=%0d ch=%0d last=%0b",
                           got.average, got.channel_index, got.last_channel);
               bad_beats++;
            end else begin
               want = expected_averages.pop_front();
               if (got !== want) begin
                  if (bad_beats < 10)
                     $display({"average mismatch: expected avg=%0d ch=%0d last=%0b,",
                               " got avg=%0d ch=%0d last=%0b"},
                              want.average, want.channel_index, want.last_channel,
                              got.average, got.channel_index, got.last_channel);
                  bad_beats++;
               end
            end
         end

         if (req.valid && req.ready) begin
            if (pix_pos == 0)
               chan_sum[chan_pos] = longint'(req.sample);
            else
               chan_sum[chan_pos] += longint'(req.sample);
            if (pix_pos + 1 >= npix) begin
               avg = (chan_sum[chan_pos] * longint'(65536 / npix)) >>> gap_pkg::FRAC_SHIFT;
               if (avg > 32767) avg = 32767;
               if (avg < -32768) avg = -32768;
               want.average       = gap_pkg::SAMPLE_BITS'(avg);
               want.channel_index = gap_pkg::CHAN_BITS'(chan_pos);
               want.last_channel  = (chan_pos + 1 >= chans);
               expected_averages.push_back(want);
            end
            chan_pos++;
            if (chan_pos >= chans) begin
               chan_pos = 0;
               pix_pos++;
               if (pix_pos >= npix) pix_pos = 0;
            end
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            reg_idx = csr_paddr[gap_pkg::CSR_ADDR_BITS-1:2];
            case (reg_idx)
               gap_pkg::REG_MAP_HEIGHT: begin
                  height_reg = csr_pwdata[gap_pkg::DIM_BITS-1:0];
                  chan_pos   = 0;
                  pix_pos    = 0;
               end
               gap_pkg::REG_MAP_WIDTH: begin
                  width_reg = csr_pwdata[gap_pkg::DIM_BITS-1:0];
                  chan_pos  = 0;
                  pix_pos   = 0;
               end
               gap_pkg::REG_CHANNEL_COUNT: begin
                  chcnt_reg = csr_pwdata[gap_pkg::CHCNT_BITS-1:0];
                  chan_pos  = 0;
                  pix_pos   = 0;
               end
               default: ;
            endcase
         end
      end
      mismatches <= bad_beats;
      pending    <= expected_averages.size();
      map_beats  <= used_dim(int'(height_reg), gap_pkg::MAX_SIDE)
                    * used_dim(int'(width_reg), gap_pkg::MAX_SIDE)
                    * used_dim(int'(chcnt_reg), gap_pkg::MAX_CHANNELS);
   end

endmodule

>>> tb/global_average_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// global_average_pool_tb
// streams channel-last feature maps through the pool under many map shapes,
// with bursty samples and a stalling average sink; the checker predicts and
// compares every average beat and this module gives the verdict
// ----------------------------------------------------------------------------
module global_average_pool_tb;

   // pause before a csr write, to let the result pipe and the reciprocal divider finish
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT   = 5000;
   // beats before the closing long map, power-on map included
   localparam int RANDOM_BEATS  = 1700;
   // columns of the closing long single-channel map
   localparam int LONG_WIDTH    = 4;
   // register slot past the last real one, writes there are ignored
   localparam logic [gap_pkg::REG_IDX_BITS-1:0] REG_SPARE = 2'd3;
   localparam logic signed [gap_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(gap_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [gap_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(gap_pkg::SAMPLE_BITS-1){1'b0}}};

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_BURSTY} sink_mode_type;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [gap_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [gap_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [gap_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   int avg_mismatches;
   int avg_pending;
   int map_beats;
   int burst_left = 0;

   gap_req_if req_bus ();
   gap_rsp_if rsp_bus ();

   global_average_pool uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gap_average_checker averages_chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (avg_mismatches),
      .pending     (avg_pending),
      .map_beats   (map_beats)
   );

   always #5 clock = ~clock;

   // known values on the channels before the first edge
   initial begin
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
   end

   // average sink: switches between always ready, ready two times in three at
   // random, and rare long stalls
   always @(posedge clock) begin : sink_pattern
      static sink_mode_type mode = READY_ALWAYS;
      static int mode_left  = 0;
      static int stall_left = 0;
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (mode)
            READY_ALWAYS: rsp_bus.ready <= 1'b1;
            READY_RANDOM: rsp_bus.ready <= ($urandom_range(0, 2) != 0);
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(4, 30);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // mostly uniform values, with the extremes, zero and minus one now and then
   function automatic logic signed [gap_pkg::SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 15))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return gap_pkg::SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // one sample beat; bursts of random length, random gaps between bursts,
   // and now and then a long burst with no gaps at all
   task automatic send_sample(input logic signed [gap_pkg::SAMPLE_BITS-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_bus.valid  <= 1'b0;
            req_bus.sample <= gap_pkg::SAMPLE_BITS'($urandom());
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // apb write, only once every expected average is out and the pipe is quiet
   task automatic write_reg(input logic [gap_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [gap_pkg::CSR_DATA_BITS-1:0] data);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (avg_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      // setup phase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      // access phase, the write lands on the edge where pready is seen
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // all three shape registers; sometimes junk above the field width, which
   // the block must drop
   task automatic set_map(input int height, input int width, input int chans);
      logic [gap_pkg::CSR_DATA_BITS-1:0] junk_dim;
      logic [gap_pkg::CSR_DATA_BITS-1:0] junk_ch;
      junk_dim = ($urandom_range(0, 3) == 0) ? ($urandom() << gap_pkg::DIM_BITS) : '0;
      junk_ch  = ($urandom_range(0, 3) == 0) ? ($urandom() << gap_pkg::CHCNT_BITS) : '0;
      write_reg(gap_pkg::REG_MAP_HEIGHT, junk_dim | gap_pkg::CSR_DATA_BITS'(height));
      write_reg(gap_pkg::REG_MAP_WIDTH, junk_dim | gap_pkg::CSR_DATA_BITS'(width));
      write_reg(gap_pkg::REG_CHANNEL_COUNT, junk_ch | gap_pkg::CSR_DATA_BITS'(chans));
   endtask

   initial begin : stimulus
      int beats;
      int random_beats;
      int drain_cycles;
      logic signed [gap_pkg::SAMPLE_BITS-1:0] fill;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      @(posedge clock);

      // power-on map, 2x2 pixels of 256 channels: channel 0 all full scale,
      // channel 1 all most negative, channel 2 a lone -1 that must floor to -1
      for (int k = 0; k < map_beats; k++) begin
         case (k % gap_pkg::MAX_CHANNELS)
            0:       send_sample(SAMPLE_MAX);
            1:       send_sample(SAMPLE_MIN);
            2:       send_sample((k < gap_pkg::MAX_CHANNELS) ? '1 : '0);
            default: send_sample(random_sample());
         endcase
      end
      random_beats = map_beats;

      // single pixel, single channel: every beat is its own average
      set_map(1, 1, 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('1);

      // zero height, width and channel count behave as one
      set_map(0, 0, 0);
      send_sample(16'sd1);
      send_sample(-16'sd256);

      // three pixels: reciprocal 21845 is inexact, negative sum floors down
      set_map(3, 1, 2);
      send_sample('1);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MAX);

      // random shapes, mostly small maps so that averages come often
      while (random_beats < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
               set_map($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 8));
            6: begin
               if ($urandom_range(0, 1))
                  set_map(gap_pkg::MAX_SIDE, $urandom_range(1, 2), $urandom_range(1, 2));
               else
                  set_map($urandom_range(1, 2), gap_pkg::MAX_SIDE, $urandom_range(1, 2));
            end
            7: set_map(1, 1, $urandom_range(0, 1) ? gap_pkg::MAX_CHANNELS
                                                  : $urandom_range(200, 511));
            8: set_map($urandom_range(0, 1) ? 0
                                            : $urandom_range(gap_pkg::MAX_SIDE + 1, 127),
                       $urandom_range(0, 3), $urandom_range(0, 1));
            // spare slot: no restart, the map carries on where it stood
            default: write_reg(REG_SPARE, $urandom());
         endcase
         beats = (map_beats <= 64) ? map_beats * $urandom_range(1, 4) : map_beats;
         // a broken-off map now and then, the next write restarts it
         if (map_beats > 1 && $urandom_range(0, 3) == 0)
            beats += $urandom_range(1, map_beats - 1);
         for (int k = 0; k < beats; k++) send_sample(random_sample());
         random_beats += beats;
      end

      // long single-channel map held at one extreme: the average must come
      // back as that same extreme
      set_map(gap_pkg::MAX_SIDE, LONG_WIDTH, 1);
      fill = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      for (int k = 0; k < map_beats; k++) send_sample(fill);

      // drain, then let any beat without an average clear the pipe
      req_bus.valid <= 1'b0;
      @(posedge clock);
      drain_cycles = 0;
      while (avg_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (avg_pending != 0)
         $display("%0d expected averages never arrived", avg_pending);
      if (avg_mismatches == 0 && avg_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
